### src/b2t_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2t_pkg: shared types and constants for the blank-to-tab compressor
// Character codes, counter widths and the command that the front end
// hands to the back end through the command queue.
// ---------------------------------------------------------------------------
package b2t_pkg;

   localparam int COL_W       = 6;
   localparam int CNT_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int MASK_W      = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   localparam logic [MASK_W-1:0] TAB_STOP_RESET = 64'h0101_0101_0101_0101;

   // one emit job: pending tabs, pending blanks, then the byte itself
   typedef struct packed {
      logic [CNT_W-1:0]  tabs;
      logic [CNT_W-1:0]  blanks;
      logic [BYTE_W-1:0] ch;
   } cmd_type;

   // push side of the queue, also used for the queue head
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

endpackage

### src/blank_to_tab_compressor_unit.sv
`timescale 1ns / 1ps
// Path: the first result a releasing byte causes passes the queue entry, then the output
//   register, before it is on the output; a full queue or an output stall can hold it.
// Throughput: one input byte per cycle while the queue is not full; a releasing byte
//   with T tabs and B blanks pending (B taken as zero for a tab) emits T+B+1 bytes.
// The four-entry command queue sets how far input runs ahead of a long burst.
// Reset: synchronous; stops every eighth column, column 1, nothing pending, queue empty.
// ---------------------------------------------------------------------------
// blank_to_tab_compressor_unit: entab with a programmable tab-stop list
// Replaces runs of spaces that reach a tab stop by tabs. The front end
// classifies bytes and tracks the column, the back end emits the bytes.
// ---------------------------------------------------------------------------
module blank_to_tab_compressor_unit #(
   parameter int LINE_COLUMNS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // input item channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [b2t_pkg::BYTE_W-1:0]    req_in_byte,
   // result item channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [b2t_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_last,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [b2t_pkg::MASK_W-1:0]    csr_pwdata,
   output logic [b2t_pkg::MASK_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import b2t_pkg::*;

   // tab_stop_mask sits at byte address 0 (64-bit registers on 8-byte spacing)
   logic [MASK_W-1:0] tab_stop_mask_ff, tab_stop_mask_in;
   logic              csr_write;
   logic              reg_sel_mask;

   cmd_slot_type      push;
   cmd_slot_type      head;
   logic              queue_full;
   logic              pop;

   assign csr_pready   = 1'b1;
   assign reg_sel_mask = (csr_paddr[3] == 1'b0);
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign tab_stop_mask_in = (csr_write && reg_sel_mask) ? csr_pwdata : tab_stop_mask_ff;
   assign csr_prdata       = reg_sel_mask ? tab_stop_mask_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_stop_mask_ff <= TAB_STOP_RESET;
      end else begin
         tab_stop_mask_ff <= tab_stop_mask_in;
      end
   end

   // front: holds spaces, tracks column, builds emit commands
   b2t_front #(
      .LINE_COLUMNS (LINE_COLUMNS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_in_byte   (req_in_byte),
      .queue_full    (queue_full),
      .tab_stop_mask (tab_stop_mask_ff),
      .req_stall     (req_stall),
      .push          (push)
   );

   // decouples the per-byte front from the burst-emitting back
   b2t_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   // back: tabs, then blanks, then the byte, through the output register
   b2t_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

### src/b2t_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2t_front: input classifier and column tracker
// Holds spaces back, tracks column and pending counts, and pushes one
// emit command for every byte that releases output.
// ---------------------------------------------------------------------------
module b2t_front #(
   parameter int LINE_COLUMNS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [b2t_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          queue_full,
   input  logic [b2t_pkg::MASK_W-1:0]    tab_stop_mask,
   output logic                          req_stall,
   output b2t_pkg::cmd_slot_type         push
);
   import b2t_pkg::*;

   localparam logic [COL_W-1:0] LAST_COLUMN = COL_W'(LINE_COLUMNS - 1);

   logic [COL_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] tabs_ff, tabs_in;
   logic [CNT_W-1:0] blanks_ff, blanks_in;

   logic             accept;
   logic             hold_space;
   logic             stop_here;
   logic [COL_W-1:0] tab_target;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign hold_space = (req_in_byte == CH_SPACE) && (column_ff < LAST_COLUMN);
   assign stop_here  = tab_stop_mask[column_ff] && (column_ff <= LAST_COLUMN);

   // column after the lowest stop at or after the current column; lower hits overwrite
   always_comb begin
      tab_target = LAST_COLUMN;
      for (int k = LINE_COLUMNS - 1; k >= 1; k--) begin
         if (tab_stop_mask[k] && (COL_W'(k) >= column_ff)) begin
            tab_target = (COL_W'(k) == LAST_COLUMN) ? LAST_COLUMN : COL_W'(k + 1);
         end
      end
   end

   always_comb begin
      column_in       = column_ff;
      tabs_in         = tabs_ff;
      blanks_in       = blanks_ff;
      push.valid      = 1'b0;
      push.cmd.tabs   = tabs_ff;
      push.cmd.blanks = (req_in_byte == CH_TAB) ? '0 : blanks_ff;
      push.cmd.ch     = req_in_byte;
      if (accept) begin
         if (hold_space) begin
            if (stop_here) begin
               tabs_in   = tabs_ff + 1'b1;
               blanks_in = '0;
            end else begin
               blanks_in = blanks_ff + 1'b1;
            end
            column_in = column_ff + 1'b1;
         end else begin
            push.valid = 1'b1;
            tabs_in    = '0;
            blanks_in  = '0;
            priority if (req_in_byte == CH_NL) begin
               column_in = COL_W'(1);
            end else if (req_in_byte == CH_TAB) begin
               column_in = tab_target;
            end else if (column_ff < LAST_COLUMN) begin
               column_in = column_ff + 1'b1;
            end else begin
               column_in = LAST_COLUMN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= COL_W'(1);
         tabs_ff   <= '0;
         blanks_ff <= '0;
      end else begin
         column_ff <= column_in;
         tabs_ff   <= tabs_in;
         blanks_ff <= blanks_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (column_ff >= COL_W'(1)) && (column_ff <= LAST_COLUMN))
      else $error("column out of range");

   a_pending_fits: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, tabs_ff} + {1'b0, blanks_ff}) < {1'b0, column_ff})
      else $error("pending count exceeds columns passed");
`endif

endmodule

### src/b2t_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2t_queue: command queue between front and back
// Small register FIFO; full feeds the input stall, head goes to the back.
// ---------------------------------------------------------------------------
module b2t_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  b2t_pkg::cmd_slot_type  push,
   input  logic                   pop,
   output b2t_pkg::cmd_slot_type  head,
   output logic                   full
);
   import b2t_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head.valid))
      else $error("pop from empty queue");
`endif

endmodule

### src/b2t_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2t_back: emit sequencer
// Walks the queue head: tabs, then blanks, then the byte, one per cycle while
// the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module b2t_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b2t_pkg::cmd_slot_type       head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [b2t_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last
);
   import b2t_pkg::*;

   logic [CNT_W-1:0]  tab_done_ff, tab_done_in;
   logic [CNT_W-1:0]  blank_done_ff, blank_done_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              advance;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      tab_done_in   = tab_done_ff;
      blank_done_in = blank_done_ff;
      valid_in      = valid_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      pop           = 1'b0;
      if (advance) begin
         valid_in = head.valid;
         if (head.valid) begin
            priority if (tab_done_ff < head.cmd.tabs) begin
               byte_in     = CH_TAB;
               last_in     = 1'b0;
               tab_done_in = tab_done_ff + 1'b1;
            end else if (blank_done_ff < head.cmd.blanks) begin
               byte_in       = CH_SPACE;
               last_in       = 1'b0;
               blank_done_in = blank_done_ff + 1'b1;
            end else begin
               byte_in       = head.cmd.ch;
               last_in       = 1'b1;
               pop           = 1'b1;
               tab_done_in   = '0;
               blank_done_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_done_ff   <= '0;
         blank_done_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         tab_done_ff   <= tab_done_in;
         blank_done_ff <= blank_done_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule
